// ===== hdl/mau_pkg.sv =====
// Shared types, constants and modular step function for the modular arithmetic unit.
`timescale 1ns / 1ps

package mau_pkg;

   localparam int WORD_BITS = 30;
   localparam int WIDE_BITS = 64;
   localparam int CNT_BITS  = 6;

   localparam logic [WORD_BITS-1:0] MOD_P     = 30'd1000000007;
   localparam logic [WORD_BITS:0]   MOD_P_EXT = {1'b0, MOD_P};
   localparam logic [WIDE_BITS-1:0] INV_EXP   = 64'd1000000005;

   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(WORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] RED_LAST = CNT_BITS'(WIDE_BITS - 1);

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_NEG    = 3'd2,
      CMD_MUL    = 3'd3,
      CMD_INV    = 3'd4,
      CMD_DIV    = 3'd5,
      CMD_POW    = 3'd6,
      CMD_REDUCE = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_INV_SETUP,
      OP_POW_SETUP,
      OP_MULA_SETUP,
      OP_MSTART,
      OP_MSTEP,
      OP_COMMIT_POW,
      OP_COMMIT_MUL,
      OP_RSTEP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    neg;
      logic    exp_zero;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INV_SETUP,
      S_POW_SETUP,
      S_POW_CHECK,
      S_MULA_SETUP,
      S_MSTART,
      S_MSTEP,
      S_MCOMMIT,
      S_RSTEP,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_INV,
      PH_POW,
      PH_MUL
   } phase_type;

   // One MSB-first step of a serial modular product: (2t + bit*y) mod P.
   function automatic logic [WORD_BITS-1:0] mod_step(logic [WORD_BITS-1:0] t,
                                                     logic bit_in,
                                                     logic [WORD_BITS-1:0] y);
      logic [WORD_BITS:0] u;
      logic [WORD_BITS:0] v;
      u = {t, 1'b0};
      if (u >= MOD_P_EXT) begin
         u = u - MOD_P_EXT;
      end
      v = u + (bit_in ? {1'b0, y} : '0);
      if (v >= MOD_P_EXT) begin
         v = v - MOD_P_EXT;
      end
      return v[WORD_BITS-1:0];
   endfunction

endpackage

// ===== hdl/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit over the prime 1000000007.
// Add, subtract and negate need no serial pass; multiply is one serial multiplier pass and
// reduce a bit-serial pass over the 64-bit value; each power step is one serial multiplier
// pass, and inverse (Fermat) is a power with a 30-bit exponent; divide and negative power add both.
// One word at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset (synchronous, active high) returns the controller to idle and clears the strobe.
`timescale 1ns / 1ps

module modular_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_command,
   input  logic [mau_pkg::WORD_BITS-1:0]        req_operand_a,
   input  logic [mau_pkg::WORD_BITS-1:0]        req_operand_b,
   input  logic signed [mau_pkg::WIDE_BITS-1:0] req_wide_value,
   output logic                                 rsp_valid,
   output logic [mau_pkg::WORD_BITS-1:0]        rsp_result,
   output logic                                 rsp_divide_by_zero
);

   mau_pkg::dp_op_type     op;
   mau_pkg::dp_status_type status;

   mau_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .op     (op)
   );

   mau_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .req_command        (req_command),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .req_wide_value     (req_wide_value),
      .rsp_valid          (rsp_valid),
      .rsp_result         (rsp_result),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ===== hdl/mau_datapath.sv =====
// Datapath: operand registers, serial modular multipliers, reduce and result logic.
`timescale 1ns / 1ps

module mau_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mau_pkg::dp_op_type             op,
   output mau_pkg::dp_status_type         status,
   input  logic [2:0]                     req_command,
   input  logic [mau_pkg::WORD_BITS-1:0]  req_operand_a,
   input  logic [mau_pkg::WORD_BITS-1:0]  req_operand_b,
   input  logic signed [mau_pkg::WIDE_BITS-1:0] req_wide_value,
   output logic                           rsp_valid,
   output logic [mau_pkg::WORD_BITS-1:0]  rsp_result,
   output logic                           rsp_divide_by_zero
);

   mau_pkg::cmd_type                 cmd_ff, cmd_in;
   logic                             neg_ff, neg_in;
   logic [mau_pkg::WORD_BITS-1:0]    a_ff, a_in;
   logic [mau_pkg::WORD_BITS-1:0]    b_ff, b_in;
   logic [mau_pkg::WIDE_BITS-1:0]    exp_ff, exp_in;
   logic [mau_pkg::WIDE_BITS-1:0]    mag_ff, mag_in;
   logic [mau_pkg::WORD_BITS-1:0]    acc_ff, acc_in;
   logic [mau_pkg::WORD_BITS-1:0]    base_ff, base_in;
   logic [mau_pkg::WORD_BITS-1:0]    t1_ff, t1_in;
   logic [mau_pkg::WORD_BITS-1:0]    t2_ff, t2_in;
   logic [mau_pkg::WORD_BITS-1:0]    m1_ff, m1_in;
   logic [mau_pkg::WORD_BITS-1:0]    m2_ff, m2_in;
   logic                             flag_ff, flag_in;
   logic                             valid_ff, valid_in;
   logic [mau_pkg::WORD_BITS-1:0]    result_ff, result_in;
   logic                             dbz_ff, dbz_in;

   logic [mau_pkg::WIDE_BITS-1:0]    wide_u;
   logic [mau_pkg::WORD_BITS-1:0]    inv_sel;
   logic [mau_pkg::WORD_BITS:0]      sum;
   logic [mau_pkg::WORD_BITS-1:0]    final_val;

   assign wide_u = req_wide_value;
   assign status = '{cmd: cmd_ff, neg: neg_ff, exp_zero: (exp_ff == '0)};
   assign inv_sel = (cmd_ff == mau_pkg::CMD_DIV) ? b_ff : a_ff;

   always_comb begin
      sum = '0;
      final_val = acc_ff;
      case (cmd_ff)
         mau_pkg::CMD_ADD: begin
            sum = {1'b0, a_ff} + {1'b0, b_ff};
            if (sum >= mau_pkg::MOD_P_EXT) begin
               sum = sum - mau_pkg::MOD_P_EXT;
            end
            final_val = sum[mau_pkg::WORD_BITS-1:0];
         end
         mau_pkg::CMD_SUB: begin
            if (a_ff >= b_ff) begin
               sum = {1'b0, a_ff} - {1'b0, b_ff};
            end else begin
               sum = {1'b0, a_ff} + mau_pkg::MOD_P_EXT - {1'b0, b_ff};
            end
            final_val = sum[mau_pkg::WORD_BITS-1:0];
         end
         mau_pkg::CMD_NEG: begin
            final_val = (a_ff == '0) ? '0 : mau_pkg::MOD_P - a_ff;
         end
         mau_pkg::CMD_REDUCE: begin
            final_val = (neg_ff && t1_ff != '0) ? mau_pkg::MOD_P - t1_ff : t1_ff;
         end
         default: begin
            final_val = acc_ff;
         end
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      neg_in    = neg_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      exp_in    = exp_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      flag_in   = flag_ff;
      valid_in  = 1'b0;
      result_in = result_ff;
      dbz_in    = dbz_ff;
      unique case (op)
         mau_pkg::OP_IDLE: begin
         end
         mau_pkg::OP_LOAD: begin
            cmd_in  = mau_pkg::cmd_type'(req_command);
            neg_in  = wide_u[mau_pkg::WIDE_BITS-1];
            a_in    = (req_operand_a >= mau_pkg::MOD_P) ? req_operand_a - mau_pkg::MOD_P
                                                        : req_operand_a;
            b_in    = (req_operand_b >= mau_pkg::MOD_P) ? req_operand_b - mau_pkg::MOD_P
                                                        : req_operand_b;
            acc_in  = (req_operand_b >= mau_pkg::MOD_P) ? req_operand_b - mau_pkg::MOD_P
                                                        : req_operand_b;
            exp_in  = wide_u[mau_pkg::WIDE_BITS-1] ? ('0 - wide_u) : wide_u;
            // exponent magnitude kept aside, the inverse pass reuses exp_ff
            mag_in  = wide_u[mau_pkg::WIDE_BITS-1] ? ('0 - wide_u) : wide_u;
            t1_in   = '0;
            flag_in = 1'b0;
         end
         mau_pkg::OP_INV_SETUP: begin
            // inverse by Fermat: x^(P-2); zero gives 1 with the flag
            acc_in  = mau_pkg::WORD_BITS'(1);
            base_in = inv_sel;
            if (inv_sel == '0) begin
               flag_in = 1'b1;
               exp_in  = '0;
            end else begin
               exp_in  = mau_pkg::INV_EXP;
            end
         end
         mau_pkg::OP_POW_SETUP: begin
            base_in = neg_ff ? acc_ff : a_ff;
            acc_in  = mau_pkg::WORD_BITS'(1);
            exp_in  = mag_ff;
         end
         mau_pkg::OP_MULA_SETUP: begin
            base_in = a_ff;
         end
         mau_pkg::OP_MSTART: begin
            m1_in = acc_ff;
            m2_in = base_ff;
            t1_in = '0;
            t2_in = '0;
         end
         mau_pkg::OP_MSTEP: begin
            t1_in = mau_pkg::mod_step(t1_ff, m1_ff[mau_pkg::WORD_BITS-1], base_ff);
            t2_in = mau_pkg::mod_step(t2_ff, m2_ff[mau_pkg::WORD_BITS-1], base_ff);
            m1_in = {m1_ff[mau_pkg::WORD_BITS-2:0], 1'b0};
            m2_in = {m2_ff[mau_pkg::WORD_BITS-2:0], 1'b0};
         end
         mau_pkg::OP_COMMIT_POW: begin
            if (exp_ff[0]) begin
               acc_in = t1_ff;
            end
            base_in = t2_ff;
            exp_in  = {1'b0, exp_ff[mau_pkg::WIDE_BITS-1:1]};
         end
         mau_pkg::OP_COMMIT_MUL: begin
            acc_in = t1_ff;
         end
         mau_pkg::OP_RSTEP: begin
            t1_in  = mau_pkg::mod_step(t1_ff, exp_ff[mau_pkg::WIDE_BITS-1],
                                       mau_pkg::WORD_BITS'(1));
            exp_in = {exp_ff[mau_pkg::WIDE_BITS-2:0], 1'b0};
         end
         mau_pkg::OP_FINISH: begin
            valid_in  = 1'b1;
            result_in = final_val;
            dbz_in    = flag_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff    <= cmd_in;
      neg_ff    <= neg_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      exp_ff    <= exp_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      t1_ff     <= t1_in;
      t2_ff     <= t2_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      flag_ff   <= flag_in;
      result_ff <= result_in;
      dbz_ff    <= dbz_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_divide_by_zero = dbz_ff;

endmodule

// ===== hdl/mau_controller.sv =====
// Controller: sequences load, inverse, power, multiply and reduce steps.
`timescale 1ns / 1ps

module mau_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mau_pkg::dp_status_type status,
   output mau_pkg::dp_op_type     op
);

   mau_pkg::state_type            state_ff, state_in;
   mau_pkg::phase_type            phase_ff, phase_in;
   logic [mau_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::S_IDLE;
         phase_ff <= mau_pkg::PH_INV;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      op       = mau_pkg::OP_IDLE;
      busy     = (state_ff != mau_pkg::S_IDLE);
      unique case (state_ff)
         mau_pkg::S_IDLE: begin
            if (start) begin
               op       = mau_pkg::OP_LOAD;
               state_in = mau_pkg::S_DISPATCH;
            end
         end
         mau_pkg::S_DISPATCH: begin
            cnt_in = '0;
            case (status.cmd) inside
               mau_pkg::CMD_MUL:    state_in = mau_pkg::S_MULA_SETUP;
               mau_pkg::CMD_INV,
               mau_pkg::CMD_DIV:    state_in = mau_pkg::S_INV_SETUP;
               mau_pkg::CMD_POW:    state_in = status.neg ? mau_pkg::S_INV_SETUP
                                                          : mau_pkg::S_POW_SETUP;
               mau_pkg::CMD_REDUCE: state_in = mau_pkg::S_RSTEP;
               default:             state_in = mau_pkg::S_FINISH;
            endcase
         end
         mau_pkg::S_INV_SETUP: begin
            op       = mau_pkg::OP_INV_SETUP;
            phase_in = mau_pkg::PH_INV;
            state_in = mau_pkg::S_POW_CHECK;
         end
         mau_pkg::S_POW_SETUP: begin
            op       = mau_pkg::OP_POW_SETUP;
            phase_in = mau_pkg::PH_POW;
            state_in = mau_pkg::S_POW_CHECK;
         end
         mau_pkg::S_POW_CHECK: begin
            if (!status.exp_zero) begin
               state_in = mau_pkg::S_MSTART;
            end else if (phase_ff == mau_pkg::PH_INV) begin
               case (status.cmd)
                  mau_pkg::CMD_DIV: state_in = mau_pkg::S_MULA_SETUP;
                  mau_pkg::CMD_POW: state_in = mau_pkg::S_POW_SETUP;
                  default:          state_in = mau_pkg::S_FINISH;
               endcase
            end else begin
               state_in = mau_pkg::S_FINISH;
            end
         end
         mau_pkg::S_MULA_SETUP: begin
            op       = mau_pkg::OP_MULA_SETUP;
            phase_in = mau_pkg::PH_MUL;
            state_in = mau_pkg::S_MSTART;
         end
         mau_pkg::S_MSTART: begin
            op       = mau_pkg::OP_MSTART;
            cnt_in   = '0;
            state_in = mau_pkg::S_MSTEP;
         end
         mau_pkg::S_MSTEP: begin
            op     = mau_pkg::OP_MSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mau_pkg::MUL_LAST) begin
               state_in = mau_pkg::S_MCOMMIT;
            end
         end
         mau_pkg::S_MCOMMIT: begin
            if (phase_ff == mau_pkg::PH_MUL) begin
               op       = mau_pkg::OP_COMMIT_MUL;
               state_in = mau_pkg::S_FINISH;
            end else begin
               op       = mau_pkg::OP_COMMIT_POW;
               state_in = mau_pkg::S_POW_CHECK;
            end
         end
         mau_pkg::S_RSTEP: begin
            op     = mau_pkg::OP_RSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mau_pkg::RED_LAST) begin
               state_in = mau_pkg::S_FINISH;
            end
         end
         mau_pkg::S_FINISH: begin
            op       = mau_pkg::OP_FINISH;
            state_in = mau_pkg::S_IDLE;
         end
         default: begin
            state_in = mau_pkg::S_IDLE;
         end
      endcase
   end

endmodule
